[rtl/seven_segment_frame_serializer_assert.svh]
`ifndef SEVEN_SEGMENT_FRAME_SERIALIZER_ASSERT_SVH
`define SEVEN_SEGMENT_FRAME_SERIALIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSFS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssfs assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssfs assertion failed");

`endif

[rtl/ssfs_pkg.sv]
package ssfs_pkg;

    localparam int FRAME_BITS = 16;
    localparam int NUM_SELECTS = 4;
    localparam logic [15:0] BLANK_FRAME = 16'hFFFF;
    localparam logic [15:0] MAX_NUMBER = 16'd9999;

    localparam logic [1:0] OP_NUMBER = 2'd0;
    localparam logic [1:0] OP_CHAR = 2'd1;
    localparam logic [1:0] OP_BLANK = 2'd2;

    localparam logic [1:0] CFG_SELECT_ONE = 2'd0;
    localparam logic [1:0] CFG_SELECT_TWO = 2'd1;
    localparam logic [1:0] CFG_SELECT_THREE = 2'd2;
    localparam logic [1:0] CFG_SELECT_FOUR = 2'd3;

    localparam logic [7:0] SELECT_ONE_RESET = 8'd241;
    localparam logic [7:0] SELECT_TWO_RESET = 8'd242;
    localparam logic [7:0] SELECT_THREE_RESET = 8'd244;
    localparam logic [7:0] SELECT_FOUR_RESET = 8'd248;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] number_value;
        logic [7:0]  char_code;
        logic [7:0]  position;
    } command_t;

    typedef struct packed {
        logic serial_bit;
        logic latch_pulse;
        logic last;
    } result_t;

    // One frame handed from front to back.
    typedef struct packed {
        logic [15:0] frame;
        logic        last;
    } frame_word_t;

    typedef logic [NUM_SELECTS-1:0][7:0] select_codes_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_NUMBER,
        KIND_CHAR,
        KIND_BLANK
    } cmd_kind_t;

    function automatic logic [7:0] digit_segments(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0: s = 8'hC0;
            4'd1: s = 8'hF9;
            4'd2: s = 8'hA4;
            4'd3: s = 8'hB0;
            4'd4: s = 8'h99;
            4'd5: s = 8'h92;
            4'd6: s = 8'h82;
            4'd7: s = 8'hF8;
            4'd8: s = 8'h80;
            4'd9: s = 8'h90;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] letter_segments(input logic [4:0] l);
        logic [7:0] s;
        case (l)
            5'd0: s = 8'd136;
            5'd1: s = 8'd131;
            5'd2: s = 8'd167;
            5'd3: s = 8'd161;
            5'd4: s = 8'd134;
            5'd5: s = 8'd142;
            5'd6: s = 8'd144;
            5'd7: s = 8'd139;
            5'd8: s = 8'd207;
            5'd9: s = 8'd241;
            5'd10: s = 8'd182;
            5'd11: s = 8'd199;
            5'd12: s = 8'd182;
            5'd13: s = 8'd171;
            5'd14: s = 8'd163;
            5'd15: s = 8'd140;
            5'd16: s = 8'd152;
            5'd17: s = 8'd175;
            5'd18: s = 8'd146;
            5'd19: s = 8'd135;
            5'd20: s = 8'd227;
            5'd21: s = 8'd182;
            5'd22: s = 8'd182;
            5'd23: s = 8'd182;
            5'd24: s = 8'd145;
            5'd25: s = 8'd182;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

    // Decimal weight of the digit produced at each step, leftmost first.
    function automatic logic [13:0] place_value(input logic [1:0] step);
        logic [13:0] v;
        case (step)
            2'd0: v = 14'd1000;
            2'd1: v = 14'd100;
            2'd2: v = 14'd10;
            default: v = 14'd1;
        endcase
        return v;
    endfunction

endpackage

[rtl/ssfs_front.sv]
module ssfs_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  ssfs_pkg::command_t     command,
    input  ssfs_pkg::select_codes_t select_codes,
    output logic                   q_push,
    output ssfs_pkg::frame_word_t  q_word,
    input  logic                   q_full
);
    import ssfs_pkg::*;

    logic       busy_reg, busy_next;
    cmd_kind_t  kind_reg, kind_next;
    logic [13:0] rem_reg, rem_next;
    logic [1:0] step_reg, step_next;
    logic [7:0] seg_reg, seg_next;
    logic [1:0] pos_reg, pos_next;

    logic        done;
    logic        accept;
    cmd_kind_t   in_kind;
    logic [7:0]  in_seg;
    logic        char_ok;
    logic [7:0]  ch;
    logic [3:0]  digit;
    logic [13:0] digit_weight;
    logic [13:0] weight;

    // Classify the incoming command and look up its character pattern.
    always_comb
    begin
        ch = command.char_code;
        char_ok = 1'b1;
        in_seg = 8'hFF;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            in_seg = digit_segments(4'(ch - 8'h30));
        end
        else if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            in_seg = letter_segments(5'(ch - 8'h61));
        end
        else if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            in_seg = letter_segments(5'(ch - 8'h41));
        end
        else
        begin
            char_ok = 1'b0;
        end

        case (command.operation)
            OP_NUMBER:
                in_kind = (command.number_value > MAX_NUMBER) ? KIND_NONE : KIND_NUMBER;
            OP_CHAR:
                in_kind = (char_ok && command.position >= 8'd1 && command.position <= 8'd4)
                          ? KIND_CHAR : KIND_NONE;
            OP_BLANK:
                in_kind = KIND_BLANK;
            default:
                in_kind = KIND_NONE;
        endcase
    end

    // One decimal digit per step: largest multiple of the weight not above the remainder.
    always_comb
    begin
        weight = place_value(step_reg);
        digit = 4'd0;
        digit_weight = 14'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_reg >= 14'(k * weight))
            begin
                digit = 4'(k);
                digit_weight = 14'(k * weight);
            end
        end
    end

    always_comb
    begin
        q_push = 1'b0;
        done = 1'b0;
        q_word.frame = BLANK_FRAME;
        q_word.last = 1'b1;
        case (kind_reg)
            KIND_NUMBER:
            begin
                q_word.frame = {digit_segments(digit), select_codes[step_reg]};
                q_word.last = (step_reg == 2'd3);
                q_push = busy_reg && !q_full;
                done = q_push && (step_reg == 2'd3);
            end
            KIND_CHAR:
            begin
                q_word.frame = {seg_reg, select_codes[pos_reg]};
                q_push = busy_reg && !q_full;
                done = q_push;
            end
            KIND_BLANK:
            begin
                q_push = busy_reg && !q_full;
                done = q_push;
            end
            default:
            begin
                done = busy_reg;
            end
        endcase
    end

    assign full = busy_reg && !done;
    assign accept = push && !full;

    always_comb
    begin
        busy_next = busy_reg;
        kind_next = kind_reg;
        rem_next = rem_reg;
        step_next = step_reg;
        seg_next = seg_reg;
        pos_next = pos_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            kind_next = in_kind;
            rem_next = command.number_value[13:0];
            step_next = 2'd0;
            seg_next = in_seg;
            pos_next = command.position[1:0] - 2'd1;
        end
        else
        begin
            if (done)
            begin
                busy_next = 1'b0;
            end
            if (q_push && kind_reg == KIND_NUMBER)
            begin
                rem_next = rem_reg - digit_weight;
                step_next = step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            kind_reg <= KIND_NONE;
            step_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            kind_reg <= kind_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        seg_reg <= seg_next;
        pos_reg <= pos_next;
    end

endmodule

[rtl/ssfs_queue.sv]
module ssfs_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ssfs_pkg::frame_word_t wdata,
    output logic                  full,
    input  logic                  pop,
    output ssfs_pkg::frame_word_t rdata,
    output logic                  valid
);
    import ssfs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_word_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/ssfs_back.sv]
module ssfs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  ssfs_pkg::frame_word_t q_word,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output ssfs_pkg::result_t     result
);
    import ssfs_pkg::*;

    logic        active_reg, active_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] shift_reg, shift_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    result_t     result_reg, result_next;

    logic out_free;
    logic advance;
    logic frame_end;

    assign out_free = !out_valid_reg || pop;
    assign advance = active_reg && out_free;
    assign frame_end = advance && (cnt_reg == 4'(FRAME_BITS - 1));
    // Load the next frame as soon as the current one sends its final bit.
    assign q_pop = q_valid && (!active_reg || frame_end);

    always_comb
    begin
        active_next = active_reg;
        shift_next = shift_reg;
        cnt_next = cnt_reg;
        last_next = last_reg;
        out_valid_next = out_valid_reg;
        result_next = result_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            result_next.serial_bit = shift_reg[15];
            result_next.latch_pulse = frame_end;
            result_next.last = frame_end && last_reg;
            shift_next = {shift_reg[14:0], 1'b0};
            cnt_next = cnt_reg + 4'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            active_next = 1'b1;
            shift_next = q_word.frame;
            last_next = q_word.last;
            cnt_next = 4'd0;
        end
        else if (frame_end)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg <= 4'd0;
        end
        else
        begin
            active_reg <= active_next;
            out_valid_reg <= out_valid_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        last_reg <= last_next;
        result_reg <= result_next;
    end

    assign empty = !out_valid_reg;
    assign result = result_reg;

endmodule

[rtl/seven_segment_frame_serializer.sv]
// Seven-segment frame serializer. Commands enter as words on push/full: show number
// (0..9999, four frames, positions one to four), show character (digit or letter at
// position 1..4, one frame) or blank (one all-ones frame); anything else makes no
// output. Each frame is the segment byte then the digit-select byte, MSB first, one
// result word per bit on empty/pop, with latch_pulse on the sixteenth bit of every
// frame and last on the final bit of the command. The output shifter sends one bit
// per cycle while results are popped; the front splits a number into digits, one
// per cycle while the queue has room, into a small frame queue ahead of it, and
// accepts the next command as soon as the previous one is queued. Select codes reset
// to 241, 242, 244, 248 and are written through cfg_valid/cfg_ready (always ready).
module seven_segment_frame_serializer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ssfs_pkg::command_t command,
    output logic               empty,
    input  logic               pop,
    output ssfs_pkg::result_t  result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import ssfs_pkg::*;

    select_codes_t select_reg, select_next;
    frame_word_t   f_word;
    frame_word_t   b_word;
    logic          f_push;
    logic          q_full;
    logic          q_valid;
    logic          b_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        select_next = select_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SELECT_ONE:   select_next[0] = cfg_data;
                CFG_SELECT_TWO:   select_next[1] = cfg_data;
                CFG_SELECT_THREE: select_next[2] = cfg_data;
                CFG_SELECT_FOUR:  select_next[3] = cfg_data;
                default:          select_next = select_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg <= {SELECT_FOUR_RESET, SELECT_THREE_RESET,
                           SELECT_TWO_RESET, SELECT_ONE_RESET};
        end
        else
        begin
            select_reg <= select_next;
        end
    end

    ssfs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .select_codes (select_reg),
        .q_push       (f_push),
        .q_word       (f_word),
        .q_full       (q_full)
    );

    ssfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (f_word),
        .full  (q_full),
        .pop   (b_pop),
        .rdata (b_word),
        .valid (q_valid)
    );

    ssfs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_word  (b_word),
        .q_pop   (b_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

[rtl/ssfs_checker.sv]
module ssfs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input ssfs_pkg::result_t  result,
    input logic               cfg_valid,
    input logic               cfg_ready
);
    import ssfs_pkg::*;

    `include "seven_segment_frame_serializer_assert.svh"

    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic       taken;

    assign taken = pop && !empty;
    assign bit_cnt_next = taken ? bit_cnt_reg + 4'd1 : bit_cnt_reg;

    // Track the bit position within the current frame from the words taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= 4'd0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    `SSFS_ASSERT_IMPLIES(latch_on_frame_end, !empty, result.latch_pulse == (bit_cnt_reg == 4'd15))
    `SSFS_ASSERT_IMPLIES(last_ends_frame, !empty && result.last, result.latch_pulse)
    `SSFS_ASSERT_NEXT(result_held, !empty && !pop, !empty && $stable(result))
    `SSFS_ASSERT_IMPLIES(cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind seven_segment_frame_serializer ssfs_checker u_ssfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
